>>> sv/led_span_role_index_mapper_top_assert.svh
// Assertion macros for the LED span role index mapper.
// Used by led_span_role_index_mapper_top; needs clk and arst_n in scope.
`ifndef LED_SPAN_ROLE_INDEX_MAPPER_TOP_ASSERT_SVH
`define LED_SPAN_ROLE_INDEX_MAPPER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define LSRIM_ASSERT_IMPLY(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error("lsrim assertion failed");

// Next-cycle implication, checked out of reset.
`define LSRIM_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("lsrim assertion failed");

`endif

>>> sv/lsrim_pkg.sv
// Shared types and constants for the LED span role index mapper.
// No dependencies.
package lsrim_pkg;

	localparam int REG_COUNT      = 8;
	localparam int SPAN_COUNT_DEF = 8;
	localparam int CFG_IDX_W      = 3;
	localparam int DESC_W         = 13;
	localparam int CNT_W          = 10;
	localparam int REV_BIT        = 10;
	localparam int ROLE_LSB       = 11;
	localparam int ROLE_W         = 2;
	localparam int IDX_W          = 16;
	localparam int PIX_W          = 13;

	// Per-span lookup data, derived from the descriptors.
	typedef struct packed {
		logic              rev;
		logic [ROLE_W-1:0] role;
		logic [PIX_W-1:0]  limit;     // role prefix including this span
		logic [IDX_W-1:0]  bias;      // start minus role prefix
		logic [IDX_W-1:0]  rev_base;  // start + count - 1 + role prefix
	} span_map_t;

endpackage

>>> sv/lsrim_prefix.sv
// Derives per-span start, role prefix and mirror base from the descriptors.
// Depends on lsrim_pkg.
module lsrim_prefix #(
	parameter int SPAN_COUNT = lsrim_pkg::SPAN_COUNT_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic [SPAN_COUNT-1:0][lsrim_pkg::DESC_W-1:0] desc,
	output lsrim_pkg::span_map_t [SPAN_COUNT-1:0]      span_map,
	output logic [lsrim_pkg::PIX_W-1:0]                total_pixels
);

	lsrim_pkg::span_map_t [SPAN_COUNT-1:0] map_d;
	lsrim_pkg::span_map_t [SPAN_COUNT-1:0] map_q;
	logic [lsrim_pkg::PIX_W-1:0]           total_d;
	logic [lsrim_pkg::PIX_W-1:0]           total_q;

	always_comb begin
		logic [lsrim_pkg::PIX_W-1:0]  start;
		logic [lsrim_pkg::PIX_W-1:0]  rpre;
		logic [lsrim_pkg::PIX_W-1:0]  cnt_i;
		logic [lsrim_pkg::PIX_W-1:0]  cnt_j;
		logic [lsrim_pkg::ROLE_W-1:0] role_i;
		start = '0;
		for (int i = 0; i < SPAN_COUNT; i++) begin
			cnt_i  = lsrim_pkg::PIX_W'(desc[i][lsrim_pkg::CNT_W-1:0]);
			role_i = desc[i][lsrim_pkg::ROLE_LSB +: lsrim_pkg::ROLE_W];
			// sum of earlier spans of the same role
			rpre = '0;
			for (int j = 0; j < i; j++) begin
				cnt_j = lsrim_pkg::PIX_W'(desc[j][lsrim_pkg::CNT_W-1:0]);
				if (desc[j][lsrim_pkg::ROLE_LSB +: lsrim_pkg::ROLE_W] == role_i) begin
					rpre = rpre + cnt_j;
				end
			end
			map_d[i].rev      = desc[i][lsrim_pkg::REV_BIT];
			map_d[i].role     = role_i;
			map_d[i].limit    = rpre + cnt_i;
			map_d[i].bias     = lsrim_pkg::IDX_W'(start) - lsrim_pkg::IDX_W'(rpre);
			map_d[i].rev_base = lsrim_pkg::IDX_W'(start) + lsrim_pkg::IDX_W'(cnt_i)
				+ lsrim_pkg::IDX_W'(rpre) - lsrim_pkg::IDX_W'(1);
			start = start + cnt_i;
		end
		total_d = start;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= '0;
			total_q <= '0;
		end else begin
			map_q   <= map_d;
			total_q <= total_d;
		end
	end

	assign span_map     = map_q;
	assign total_pixels = total_q;

endmodule

>>> sv/lsrim_lookup.sv
// Finds the first span of the requested role that holds the index and maps it.
// Depends on lsrim_pkg.
module lsrim_lookup #(
	parameter int SPAN_COUNT = lsrim_pkg::SPAN_COUNT_DEF
) (
	input  lsrim_pkg::span_map_t [SPAN_COUNT-1:0] span_map,
	input  logic [lsrim_pkg::ROLE_W-1:0]          strip_role,
	input  logic [lsrim_pkg::IDX_W-1:0]           logical_index,
	output logic [lsrim_pkg::PIX_W-1:0]           physical_index,
	output logic                                  found
);

	logic [SPAN_COUNT-1:0]                          hit;
	logic [SPAN_COUNT-1:0][lsrim_pkg::IDX_W-1:0]    cand;

	always_comb begin
		for (int i = 0; i < SPAN_COUNT; i++) begin
			hit[i] = (span_map[i].role == strip_role)
				&& (logical_index < lsrim_pkg::IDX_W'(span_map[i].limit));
			cand[i] = span_map[i].rev ? (span_map[i].rev_base - logical_index)
				: (logical_index + span_map[i].bias);
		end
	end

	// lowest span wins
	always_comb begin
		found          = 1'b0;
		physical_index = '0;
		for (int i = SPAN_COUNT - 1; i >= 0; i--) begin
			if (hit[i]) begin
				found          = 1'b1;
				physical_index = cand[i][lsrim_pkg::PIX_W-1:0];
			end
		end
	end

endmodule

>>> sv/led_span_role_index_mapper_top.sv
// Results come from the result register; one item per cycle sustained while out_stall is low.
// Path: input register, single-pass span match and offset add, result register.
// Span tables are re-derived from the descriptors every cycle; a descriptor write
// applies to items accepted from the following cycle on.
// Reset (arst_n low, asynchronous) clears descriptors, derived tables and valids.
// A held result stalls the input only once the input register also holds an item.
module led_span_role_index_mapper_top #(
	parameter int SPAN_COUNT = lsrim_pkg::SPAN_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [lsrim_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lsrim_pkg::DESC_W-1:0]       cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [lsrim_pkg::ROLE_W-1:0]       strip_role,
	input  logic [lsrim_pkg::IDX_W-1:0]        logical_index,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lsrim_pkg::PIX_W-1:0]        physical_index,
	output logic                               found,
	output logic [lsrim_pkg::PIX_W-1:0]        total_pixels
);

	`include "led_span_role_index_mapper_top_assert.svh"

	logic [SPAN_COUNT-1:0][lsrim_pkg::DESC_W-1:0] desc_q;
	lsrim_pkg::span_map_t [SPAN_COUNT-1:0]        span_map;
	logic [lsrim_pkg::PIX_W-1:0]                  total;

	logic                          valid_s1;
	logic [lsrim_pkg::ROLE_W-1:0]  role_s1;
	logic [lsrim_pkg::IDX_W-1:0]   idx_s1;
	logic                          valid_s2;
	logic [lsrim_pkg::PIX_W-1:0]   phys_s2;
	logic                          found_s2;
	logic [lsrim_pkg::PIX_W-1:0]   total_s2;

	logic [lsrim_pkg::PIX_W-1:0]   phys_d;
	logic                          found_d;
	logic                          adv_out;
	logic                          adv_s1;

	// descriptor registers; writes past the used spans drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= '0;
		end else begin
			for (int i = 0; i < SPAN_COUNT; i++) begin
				if (cfg_we && (cfg_index == lsrim_pkg::CFG_IDX_W'(i))) begin
					desc_q[i] <= cfg_data;
				end
			end
		end
	end

	lsrim_prefix #(.SPAN_COUNT(SPAN_COUNT)) u_prefix (
		.clk          (clk),
		.arst_n       (arst_n),
		.desc         (desc_q),
		.span_map     (span_map),
		.total_pixels (total)
	);

	assign adv_out  = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_out;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_out) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && adv_s1) begin
			role_s1 <= strip_role;
			idx_s1  <= logical_index;
		end
		if (valid_s1 && adv_out) begin
			phys_s2  <= phys_d;
			found_s2 <= found_d;
			total_s2 <= total;
		end
	end

	lsrim_lookup #(.SPAN_COUNT(SPAN_COUNT)) u_lookup (
		.span_map       (span_map),
		.strip_role     (role_s1),
		.logical_index  (idx_s1),
		.physical_index (phys_d),
		.found          (found_d)
	);

	assign out_valid      = valid_s2;
	assign physical_index = phys_s2;
	assign found          = found_s2;
	assign total_pixels   = total_s2;

	`LSRIM_ASSERT_IMPLY(a_miss_zero, valid_s2 && !found_s2, phys_s2 == '0)
	`LSRIM_ASSERT_IMPLY(a_stall_full, in_stall, valid_s1 && valid_s2 && out_stall)
	`LSRIM_ASSERT_NEXT(a_s1_moves, valid_s1 && adv_out, valid_s2)

endmodule
